// ===== design/mdc22_pkg.sv =====
// ----------------------------------------------------------------------------
// mdc22_pkg: shared types and constants for the clause-22 MDIO master
// Frame lengths, field widths and the structs that pass between the
// front end, the command queue and the frame engine.
// ----------------------------------------------------------------------------
package mdc22_pkg;

    localparam int PREAMBLE_BITS = 32;
    localparam int FIELD_BITS    = 5;
    localparam int IDLE_CLOCKS   = 32;
    localparam int DATA_BITS     = 16;

    localparam int ADDR_W   = 2 * FIELD_BITS;
    localparam int THRESH_W = ADDR_W + 1;
    localparam int BC_W     = 6;
    localparam int BC_INC_W = BC_W + 1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(768);
    localparam logic [DATA_BITS-1:0] NO_PHY_DATA = '1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified item as it sits in the queue
    typedef struct packed {
        logic                  is_start;
        logic                  is_write;
        logic [FIELD_BITS-1:0] phy;
        logic [FIELD_BITS-1:0] regad;
        logic [DATA_BITS-1:0]  wdata;
        logic                  twice;
        logic                  mdio_in;
    } mdc22_cmd_t;

    // One result item
    typedef struct packed {
        logic                 mdc_level;
        logic                 mdio_out;
        logic                 mdio_drive;
        logic                 busy;
        logic                 done;
        logic [DATA_BITS-1:0] read_data;
        logic                 no_phy;
    } mdc22_res_t;

endpackage

// ===== design/mdc22_front.sv =====
// ----------------------------------------------------------------------------
// mdc22_front: request intake and classification
// Holds the double-read threshold and turns each incoming item into a
// queue command: start or tick, split address, double-read decision.
// ----------------------------------------------------------------------------
module mdc22_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mdc22_pkg::THRESH_W-1:0]  cfg_wr_data,
    input  logic                            s_req_type,
    input  logic                            s_is_write,
    input  logic [mdc22_pkg::ADDR_W-1:0]    s_device_addr,
    input  logic [mdc22_pkg::DATA_BITS-1:0] s_write_data,
    input  logic                            s_mdio_in,
    output mdc22_pkg::mdc22_cmd_t           cmd
);
    import mdc22_pkg::*;

    logic [THRESH_W-1:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        cmd.is_start = ~s_req_type;
        cmd.is_write = s_is_write;
        cmd.phy      = s_device_addr[ADDR_W-1:FIELD_BITS];
        cmd.regad    = s_device_addr[FIELD_BITS-1:0];
        cmd.wdata    = s_write_data;
        // reads at or above the threshold run a second pass
        cmd.twice    = ~s_is_write && ({1'b0, s_device_addr} >= thresh_reg);
        cmd.mdio_in  = s_mdio_in;
    end

endmodule

// ===== design/mdc22_queue.sv =====
// ----------------------------------------------------------------------------
// mdc22_queue: small command queue
// Register FIFO between the front end and the frame engine.
// ----------------------------------------------------------------------------
module mdc22_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  mdc22_pkg::mdc22_cmd_t push_cmd,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output mdc22_pkg::mdc22_cmd_t pop_cmd
);
    import mdc22_pkg::*;

    mdc22_cmd_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/mdc22_engine.sv =====
// ----------------------------------------------------------------------------
// mdc22_engine: clause-22 frame sequencer
// Executes one queued command per cycle unless the result is stalled:
// starts an access or advances the frame by one half period, and
// registers the resulting pin and status item.
module mdc22_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  mdc22_pkg::mdc22_cmd_t cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output mdc22_pkg::mdc22_res_t res
);
    import mdc22_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_PRE   = 4'd1;
    localparam logic [3:0] PH_ST    = 4'd2;
    localparam logic [3:0] PH_OP    = 4'd3;
    localparam logic [3:0] PH_PA    = 4'd4;
    localparam logic [3:0] PH_RA    = 4'd5;
    localparam logic [3:0] PH_RTA   = 4'd6;
    localparam logic [3:0] PH_RCHK  = 4'd7;
    localparam logic [3:0] PH_RDATA = 4'd8;
    localparam logic [3:0] PH_RIDLE = 4'd9;
    localparam logic [3:0] PH_RTAIL = 4'd10;
    localparam logic [3:0] PH_WTA   = 4'd11;
    localparam logic [3:0] PH_WDATA = 4'd12;
    localparam logic [3:0] PH_WTAIL = 4'd13;

    localparam int FI_W = $clog2(FIELD_BITS);

    logic [3:0]            phase_reg,   phase_next;
    logic [BC_W-1:0]       bc_reg,      bc_next;
    logic                  half_reg,    half_next;
    logic [DATA_BITS-1:0]  shift_reg,   shift_next;
    logic                  wr_reg,      wr_next;
    logic [FIELD_BITS-1:0] phy_reg,     phy_next;
    logic [FIELD_BITS-1:0] ra_reg,      ra_next;
    logic                  pend_reg,    pend_next;
    logic                  pnophy_reg,  pnophy_next;
    logic                  mdc_reg,     mdc_next;
    logic                  dout_reg,    dout_next;
    logic                  drive_reg,   drive_next;
    logic [DATA_BITS-1:0]  rdata_reg,   rdata_next;
    logic                  rnophy_reg,  rnophy_next;
    logic                  res_valid_reg;
    mdc22_res_t            res_reg;

    logic                  fire;
    logic                  done;
    logic                  end_pass;
    logic                  send;
    logic [BC_INC_W-1:0]   bc_inc;

    function automatic logic [BC_INC_W-1:0] phase_len(input logic [3:0] ph);
        logic [BC_INC_W-1:0] len;
        len = BC_INC_W'(2);
        if (ph == PH_PRE) begin
            len = BC_INC_W'(PREAMBLE_BITS);
        end else if (ph == PH_PA || ph == PH_RA) begin
            len = BC_INC_W'(FIELD_BITS);
        end else if (ph == PH_WDATA) begin
            len = BC_INC_W'(DATA_BITS);
        end
        return len;
    endfunction

    function automatic logic field_bit(input logic [FIELD_BITS-1:0] v,
                                       input logic [BC_W-1:0] i);
        logic [FI_W-1:0] sh;
        sh = FI_W'(FIELD_BITS - 1) - i[FI_W-1:0];
        return v[sh];
    endfunction

    assign fire      = cmd_valid && (!res_valid_reg || res_ready);
    assign cmd_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign bc_inc    = {1'b0, bc_reg} + 1'b1;

    always_comb begin
        send = shift_reg[DATA_BITS-1];
        unique case (phase_reg)
            PH_PRE:  send = 1'b1;
            PH_ST:   send = (bc_reg == BC_W'(1));
            PH_OP:   send = wr_reg ? (bc_reg == BC_W'(1)) : (bc_reg == '0);
            PH_PA:   send = field_bit(phy_reg, bc_reg);
            PH_RA:   send = field_bit(ra_reg, bc_reg);
            PH_WTA:  send = (bc_reg == '0);
            default: send = shift_reg[DATA_BITS-1];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        bc_next     = bc_reg;
        half_next   = half_reg;
        shift_next  = shift_reg;
        wr_next     = wr_reg;
        phy_next    = phy_reg;
        ra_next     = ra_reg;
        pend_next   = pend_reg;
        pnophy_next = pnophy_reg;
        mdc_next    = mdc_reg;
        dout_next   = dout_reg;
        drive_next  = drive_reg;
        rdata_next  = rdata_reg;
        rnophy_next = rnophy_reg;
        done        = 1'b0;
        end_pass    = 1'b0;

        if (cmd.is_start) begin
            // ignore a start while busy
            if (phase_reg == PH_IDLE) begin
                wr_next     = cmd.is_write;
                phy_next    = cmd.phy;
                ra_next     = cmd.regad;
                pend_next   = cmd.twice;
                phase_next  = PH_PRE;
                bc_next     = '0;
                half_next   = 1'b0;
                pnophy_next = 1'b0;
                shift_next  = cmd.is_write ? cmd.wdata : '0;
            end
        end else begin
            unique case (phase_reg)
                PH_PRE, PH_ST, PH_OP, PH_PA, PH_RA, PH_WTA, PH_WDATA: begin
                    if (!half_reg) begin
                        drive_next = 1'b1;
                        dout_next  = send;
                        mdc_next   = 1'b0;
                        half_next  = 1'b1;
                    end else begin
                        mdc_next  = 1'b1;
                        half_next = 1'b0;
                        if (phase_reg == PH_WDATA) begin
                            shift_next = {shift_reg[DATA_BITS-2:0], 1'b0};
                        end
                        if (bc_inc >= phase_len(phase_reg)) begin
                            bc_next = '0;
                            unique case (phase_reg)
                                PH_RA:    phase_next = wr_reg ? PH_WTA : PH_RTA;
                                PH_WDATA: phase_next = PH_WTAIL;
                                PH_WTA:   phase_next = PH_WDATA;
                                default:  phase_next = phase_reg + 1'b1;
                            endcase
                        end else begin
                            bc_next = bc_inc[BC_W-1:0];
                        end
                    end
                end
                PH_RTA: begin
                    drive_next = 1'b0;
                    dout_next  = 1'b0;
                    mdc_next   = bc_reg[0];
                    if (bc_inc >= BC_INC_W'(4)) begin
                        bc_next    = '0;
                        phase_next = PH_RCHK;
                    end else begin
                        bc_next = bc_inc[BC_W-1:0];
                    end
                end
                PH_RCHK: begin
                    mdc_next = 1'b0;
                    if (cmd.mdio_in) begin
                        // no PHY pulled the turnaround low
                        pnophy_next = 1'b1;
                        shift_next  = NO_PHY_DATA;
                        bc_next     = BC_W'(1);
                        phase_next  = PH_RIDLE;
                    end else begin
                        bc_next    = '0;
                        half_next  = 1'b0;
                        phase_next = PH_RDATA;
                    end
                end
                PH_RIDLE: begin
                    mdc_next = bc_reg[0];
                    bc_next  = bc_inc[BC_W-1:0];
                    end_pass = (bc_inc >= BC_INC_W'(2 * IDLE_CLOCKS));
                end
                PH_RDATA: begin
                    if (!half_reg) begin
                        mdc_next  = 1'b1;
                        half_next = 1'b1;
                    end else begin
                        shift_next = {shift_reg[DATA_BITS-2:0], cmd.mdio_in};
                        mdc_next   = 1'b0;
                        half_next  = 1'b0;
                        if (bc_inc >= BC_INC_W'(DATA_BITS)) begin
                            bc_next    = '0;
                            phase_next = PH_RTAIL;
                        end else begin
                            bc_next = bc_inc[BC_W-1:0];
                        end
                    end
                end
                PH_RTAIL: begin
                    mdc_next = (bc_reg != BC_W'(1));
                    bc_next  = bc_inc[BC_W-1:0];
                    end_pass = (bc_inc >= BC_INC_W'(3));
                end
                PH_WTAIL: begin
                    drive_next = 1'b0;
                    dout_next  = 1'b0;
                    if (bc_reg == '0) begin
                        mdc_next = 1'b0;
                        bc_next  = BC_W'(1);
                    end else begin
                        mdc_next   = 1'b1;
                        phase_next = PH_IDLE;
                        bc_next    = '0;
                        half_next  = 1'b0;
                        done       = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (end_pass) begin
                if (pend_reg) begin
                    // rerun the read, drop the first result
                    pend_next   = 1'b0;
                    phase_next  = PH_PRE;
                    bc_next     = '0;
                    half_next   = 1'b0;
                    pnophy_next = 1'b0;
                    shift_next  = '0;
                end else begin
                    rdata_next  = shift_next;
                    rnophy_next = pnophy_next;
                    phase_next  = PH_IDLE;
                    bc_next     = '0;
                    half_next   = 1'b0;
                    done        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bc_reg        <= '0;
            half_reg      <= 1'b0;
            shift_reg     <= '0;
            wr_reg        <= 1'b0;
            phy_reg       <= '0;
            ra_reg        <= '0;
            pend_reg      <= 1'b0;
            pnophy_reg    <= 1'b0;
            mdc_reg       <= 1'b1;
            dout_reg      <= 1'b0;
            drive_reg     <= 1'b0;
            rdata_reg     <= '0;
            rnophy_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg  <= phase_next;
                bc_reg     <= bc_next;
                half_reg   <= half_next;
                shift_reg  <= shift_next;
                wr_reg     <= wr_next;
                phy_reg    <= phy_next;
                ra_reg     <= ra_next;
                pend_reg   <= pend_next;
                pnophy_reg <= pnophy_next;
                mdc_reg    <= mdc_next;
                dout_reg   <= dout_next;
                drive_reg  <= drive_next;
                rdata_reg  <= rdata_next;
                rnophy_reg <= rnophy_next;
            end
            if (fire) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg.mdc_level  <= mdc_next;
            res_reg.mdio_out   <= drive_next & dout_next;
            res_reg.mdio_drive <= drive_next;
            res_reg.busy       <= (phase_next != PH_IDLE);
            res_reg.done       <= done;
            res_reg.read_data  <= rdata_next;
            res_reg.no_phy     <= rnophy_next;
        end
    end

endmodule

// ===== design/mdio_clause22_master_top.sv =====
// ----------------------------------------------------------------------------
// mdio_clause22_master_top: clause-22 MDIO management master
// Requests and half-period ticks enter on the s_ channel; every item
// yields one pin and status item on the m_ channel.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  s_       | s_valid / s_ready  | req_type, is_write, device_addr,
//           |                    | write_data, mdio_in
//  m_       | m_valid / m_ready  | mdc_level, mdio_out, mdio_drive, busy_res,
//           |                    | done_res, read_data, no_phy
//  cfg      | cfg_wr_en          | cfg_wr_data (double-read threshold)
//
//  One item per cycle sustained while m_ does not stall; an item's result
//  passes through the two-entry queue and then the frame engine's
//  output register. The engine's registered state update sets the rate.
//  Reset is synchronous and active low.
//  A stall on m_ fills the queue, after which s_ready drops.
//
module mdio_clause22_master_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mdc22_pkg::THRESH_W-1:0]  cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic                            s_is_write,
    input  logic [mdc22_pkg::ADDR_W-1:0]    s_device_addr,
    input  logic [mdc22_pkg::DATA_BITS-1:0] s_write_data,
    input  logic                            s_mdio_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_mdc_level,
    output logic                            m_mdio_out,
    output logic                            m_mdio_drive,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic [mdc22_pkg::DATA_BITS-1:0] m_read_data,
    output logic                            m_no_phy
);
    import mdc22_pkg::*;

    mdc22_cmd_t front_cmd;
    mdc22_cmd_t q_cmd;
    logic       q_valid;
    logic       q_ready;
    mdc22_res_t res;

    mdc22_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_req_type    (s_req_type),
        .s_is_write    (s_is_write),
        .s_device_addr (s_device_addr),
        .s_write_data  (s_write_data),
        .s_mdio_in     (s_mdio_in),
        .cmd           (front_cmd)
    );

    mdc22_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    mdc22_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_mdc_level  = res.mdc_level;
    assign m_mdio_out   = res.mdio_out;
    assign m_mdio_drive = res.mdio_drive;
    assign m_busy_res   = res.busy;
    assign m_done_res   = res.done;
    assign m_read_data  = res.read_data;
    assign m_no_phy     = res.no_phy;

endmodule
